// File: design/pwa_pkg.sv
package pwa_pkg;

   localparam int MaxPages  = 1024;
   localparam int PageBits  = 12;
   localparam int PageIdxW  = $clog2(MaxPages);
   localparam int CountW    = PageIdxW + 1;
   localparam int AddrW     = 40;
   localparam int LenW      = 32;
   localparam int StatusW   = 2;

   localparam logic [StatusW-1:0] StatusOk       = 2'd0;
   localparam logic [StatusW-1:0] StatusBadArg   = 2'd1;
   localparam logic [StatusW-1:0] StatusNoSpace  = 2'd2;
   localparam logic [StatusW-1:0] StatusMismatch = 2'd3;

   localparam logic CmdAlloc = 1'b0;
   localparam logic CmdFree  = 1'b1;

   localparam logic [1:0] CsrPageCount  = 2'd0;
   localparam logic [1:0] CsrEnabled    = 2'd1;
   localparam logic [1:0] CsrWindowBase = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request and run the checks
      logic clear_step; // clear one map and length entry (reset sweep)
      logic scan_step;  // examine one page of the map
      logic mark_step;  // set or clear one page of the run
      logic write_len;  // write the run length at the run's first page
      logic finish;     // latch the result into the output register
   } pwa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic checks_fail;  // request resolves without touching the map
      logic is_free;
      logic scan_hit;     // the run being scanned is complete
      logic scan_end;     // last page of the window examined
      logic mark_end;     // last page of the run written
      logic len_match;    // recorded run length matches the request
      logic sweep_end;    // last entry cleared
   } pwa_sts_type;

endpackage

// File: design/page_window_allocator_unit.sv
// Page window allocator: first-fit contiguous page allocation over a window.
// Requests arrive on the req_ channel (req_cmd, req_byte_length,
// req_region_address); a transfer happens when req_valid is high and
// req_stall is low. Every request yields exactly one transfer on the rsp_
// channel carrying rsp_status and rsp_granted_address.
// The csr_ port writes page_count, enabled and window_base; the user must write
// them only while idle, as the block does not enforce it. The block serves one
// request at a time. An allocation scans the page map one page per cycle, then
// marks the run one page per cycle and records the run length at its first page;
// a failed search ends at the last page of the window. A free looks up the
// recorded run length and, if it matches the request, clears the run and its
// length; a free with a length mismatch and a rejected request leave the map
// untouched. The serial map scan sets the rate.
// After reset both memories are cleared one entry per cycle over their full
// depth, during which req_stall stays high; csr writes are taken.
// The result sits in an output register; while rsp_stall is high it holds
// and the next request waits in the controller before completing.
module page_window_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [pwa_pkg::AddrW-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [pwa_pkg::LenW-1:0]      req_byte_length,
   input  logic [pwa_pkg::AddrW-1:0]     req_region_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pwa_pkg::StatusW-1:0]   rsp_status,
   output logic [pwa_pkg::AddrW-1:0]     rsp_granted_address
);

   pwa_pkg::pwa_cmd_type cmd;
   pwa_pkg::pwa_sts_type sts;
   logic                 out_busy;

   // The controller sequences the sweep, checks, scan, lookup and mark phases.
   pwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_busy  (out_busy),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the map, the length memory and the result register.
   pwa_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_cmd             (req_cmd),
      .req_byte_length     (req_byte_length),
      .req_region_address  (req_region_address),
      .out_busy            (out_busy),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address)
   );

endmodule

// File: design/pwa_ctrl.sv
module pwa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 out_busy,
   input  pwa_pkg::pwa_sts_type sts,
   output pwa_pkg::pwa_cmd_type cmd
);

   typedef enum logic [2:0] {
      SWEEP, IDLE, CHECK, SCAN, LOOKUP, MARK, SETLEN, DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         SWEEP: begin
            cmd.clear_step = 1'b1;
            if (sts.sweep_end) state_in = IDLE;
         end
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (sts.checks_fail) state_in = DONE;
            else if (sts.is_free) state_in = LOOKUP;
            else state_in = SCAN;
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit) state_in = MARK;
            else if (sts.scan_end) state_in = DONE;
         end
         LOOKUP: begin
            // Registered read of the run length settles in this cycle.
            if (sts.len_match) state_in = MARK;
            else state_in = DONE;
         end
         MARK: begin
            cmd.mark_step = 1'b1;
            if (sts.mark_end) state_in = SETLEN;
         end
         SETLEN: begin
            cmd.write_len = 1'b1;
            state_in = DONE;
         end
         DONE: begin
            if (!out_busy) begin
               cmd.finish = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   assign req_stall = (state_ff != IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= SWEEP;
      else state_ff <= state_in;
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.clear_step, cmd.scan_step, cmd.mark_step,
                cmd.write_len, cmd.finish}))
      else $error("more than one datapath command");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !req_stall)
      else $error("load outside idle");
   a_check_next: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == CHECK)
      else $error("load not followed by check");
endmodule

// File: design/pwa_datapath.sv
module pwa_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  pwa_pkg::pwa_cmd_type               cmd,
   output pwa_pkg::pwa_sts_type               sts,
   input  logic                               csr_write_enable,
   input  logic [1:0]                         csr_index,
   input  logic [pwa_pkg::AddrW-1:0]          csr_write_data,
   input  logic                               req_cmd,
   input  logic [pwa_pkg::LenW-1:0]           req_byte_length,
   input  logic [pwa_pkg::AddrW-1:0]          req_region_address,
   output logic                               out_busy,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [pwa_pkg::StatusW-1:0]        rsp_status,
   output logic [pwa_pkg::AddrW-1:0]          rsp_granted_address
);

   localparam int IW = pwa_pkg::PageIdxW;
   localparam int CW = pwa_pkg::CountW;
   localparam int AW = pwa_pkg::AddrW;
   localparam int LW = pwa_pkg::LenW;
   // Width of a byte length covering a full window, plus rounding headroom.
   localparam int WW = CW + pwa_pkg::PageBits + 1;
   localparam int NW = LW - pwa_pkg::PageBits + 1;

   logic [CW-1:0] page_count_ff;
   logic          enabled_ff;
   logic [AW-1:0] window_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff  <= '0;
         enabled_ff     <= 1'b0;
         window_base_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pwa_pkg::CsrPageCount:  page_count_ff  <= csr_write_data[CW-1:0];
            pwa_pkg::CsrEnabled:    enabled_ff     <= csr_write_data[0];
            pwa_pkg::CsrWindowBase: window_base_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Effective page count, clamped to the map depth.
   logic [CW-1:0] np;
   assign np = (page_count_ff > CW'(pwa_pkg::MaxPages)) ? CW'(pwa_pkg::MaxPages)
                                                       : page_count_ff;

   // Request capture.
   logic          is_free_ff;
   logic [LW-1:0] len_ff;
   logic [AW-1:0] addr_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_free_ff <= req_cmd;
         len_ff     <= req_byte_length;
         addr_ff    <= req_region_address;
      end
   end

   // Argument checks on the captured request.
   logic [WW-1:0] wsize;
   logic [NW-1:0] need;
   logic [AW-1:0] off;
   logic [AW-1:0] page_w;
   logic          len_bad, addr_bad, fit_bad, chk_fail;
   logic [pwa_pkg::StatusW-1:0] chk_status;
   assign wsize  = WW'(np) << pwa_pkg::PageBits;
   assign need   = NW'(({1'b0, len_ff} + (LW+1)'((1 << pwa_pkg::PageBits) - 1))
                       >> pwa_pkg::PageBits);
   assign off    = addr_ff - window_base_ff;
   assign page_w = off >> pwa_pkg::PageBits;
   assign len_bad  = (len_ff == '0) || (AW'(len_ff) > AW'(wsize));
   assign addr_bad = (addr_ff < window_base_ff) ||
                     (off[pwa_pkg::PageBits-1:0] != '0) || (off >= AW'(wsize));
   assign fit_bad  = (AW'(need) > (AW'(np) - page_w));

   always_comb begin
      chk_fail   = 1'b1;
      chk_status = pwa_pkg::StatusOk;
      if (is_free_ff && addr_bad) chk_status = pwa_pkg::StatusBadArg;
      else if (len_bad) chk_status = pwa_pkg::StatusBadArg;
      else if (is_free_ff && fit_bad) chk_status = pwa_pkg::StatusBadArg;
      else if (!enabled_ff) chk_status = pwa_pkg::StatusNoSpace;
      else chk_fail = 1'b0;
   end

   // Page map and run length store. Both are memories with registered reads,
   // swept to zero after reset. The map is read at the position that the
   // pointer takes next, so the scan sees one page per cycle.
   logic          used_mem   [pwa_pkg::MaxPages];
   logic [CW-1:0] runlen_mem [pwa_pkg::MaxPages];
   logic          used_rd_ff;
   logic [CW-1:0] runlen_rd_ff;

   logic [CW-1:0] ptr_ff, ptr_in;  // scan or mark position, also sweep index
   logic [CW-1:0] run_ff;    // free pages seen in the current run
   logic [CW-1:0] start_ff;  // first page of the run
   logic [CW-1:0] left_ff;   // pages left to mark
   logic          found_ff;  // the run was marked, so the request succeeded
   logic [pwa_pkg::StatusW-1:0] res_status_ff;
   logic [AW-1:0]               res_addr_ff;
   logic          cur_used;
   logic [CW-1:0] run_next;
   logic          hit;
   logic          free_setup;

   assign cur_used = used_rd_ff;
   assign run_next = run_ff + CW'(1);
   assign hit      = !cur_used && (NW'(run_next) == need);
   // While a free waits for its length check, the mark range follows the request.
   assign free_setup = is_free_ff && !cmd.clear_step && !cmd.load && !cmd.scan_step &&
                       !cmd.mark_step && !cmd.write_len && !cmd.finish;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.clear_step || cmd.mark_step) ptr_in = ptr_ff + CW'(1);
      else if (cmd.load) ptr_in = '0;
      else if (cmd.scan_step) ptr_in = hit ? ptr_ff + CW'(1) - CW'(need) : ptr_ff + CW'(1);
      else if (free_setup) ptr_in = page_w[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) ptr_ff <= '0;
      else ptr_ff <= ptr_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         run_ff   <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.scan_step) begin
         if (cur_used) run_ff <= '0;
         else run_ff <= run_next;
         if (hit) begin
            start_ff <= ptr_ff + CW'(1) - CW'(need);
            left_ff  <= CW'(need);
         end
      end
      if (cmd.mark_step) begin
         left_ff  <= left_ff - CW'(1);
         found_ff <= 1'b1;
      end
      if (free_setup) begin
         start_ff <= page_w[CW-1:0];
         left_ff  <= CW'(need);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         used_mem[ptr_ff[IW-1:0]]   <= 1'b0;
         runlen_mem[ptr_ff[IW-1:0]] <= '0;
      end
      if (cmd.mark_step) used_mem[ptr_ff[IW-1:0]] <= !is_free_ff;
      if (cmd.write_len)
         runlen_mem[start_ff[IW-1:0]] <= is_free_ff ? '0 : CW'(need);
      used_rd_ff   <= used_mem[ptr_in[IW-1:0]];
      runlen_rd_ff <= runlen_mem[page_w[IW-1:0]];
   end

   assign sts.checks_fail = chk_fail;
   assign sts.is_free     = is_free_ff;
   assign sts.scan_hit    = hit;
   assign sts.scan_end    = (ptr_ff + CW'(1)) >= np;
   assign sts.mark_end    = (left_ff == CW'(1));
   assign sts.len_match   = (NW'(runlen_rd_ff) == need);
   assign sts.sweep_end   = (ptr_ff == CW'(pwa_pkg::MaxPages - 1));

   // Result register: status and address for the finished request.
   logic                        valid_ff;
   logic [pwa_pkg::StatusW-1:0] fin_status;
   logic [AW-1:0]               fin_addr;
   always_comb begin
      fin_status = pwa_pkg::StatusNoSpace;
      fin_addr   = '0;
      if (chk_fail) fin_status = chk_status;
      else if (found_ff) begin
         fin_status = pwa_pkg::StatusOk;
         if (!is_free_ff) fin_addr = window_base_ff + (AW'(start_ff) << pwa_pkg::PageBits);
      end else if (is_free_ff) fin_status = pwa_pkg::StatusMismatch;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.finish) valid_ff <= 1'b1;
      else if (!rsp_stall) valid_ff <= 1'b0;
      if (cmd.finish) begin
         res_status_ff <= fin_status;
         res_addr_ff   <= fin_addr;
      end
   end

   assign out_busy            = valid_ff && rsp_stall;
   assign rsp_valid           = valid_ff;
   assign rsp_status          = res_status_ff;
   assign rsp_granted_address = res_addr_ff;

   a_ok_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pwa_pkg::StatusOk |-> rsp_granted_address == '0)
      else $error("address on failed request");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !out_busy)
      else $error("result overwritten");
   a_mark_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_step |-> ptr_ff < np)
      else $error("mark beyond window");
endmodule
